// File: rtl/mlp_pkg.sv
`default_nettype none
package mlp_pkg;

  localparam int MAX_LAYERS_DEF = 4;
  localparam int MAX_WIDTH_DEF  = 16;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_FEED   = 2'd2;

  localparam logic [2:0] REG_LAYER_COUNT  = 3'd0;
  localparam logic [2:0] REG_WIDTH_IN     = 3'd1;
  localparam logic [2:0] REG_WIDTH_HID1   = 3'd2;
  localparam logic [2:0] REG_WIDTH_HID2   = 3'd3;
  localparam logic [2:0] REG_WIDTH_HID3   = 3'd4;
  localparam logic [2:0] REG_WIDTH_OUT4   = 3'd5;

  typedef struct packed {
    logic take;
    logic acc_load;
    logic prod_en;
    logic acc_add;
    logic act_wr;
    logic src_bank;
    logic rd_col;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/mlp_leaky_relu_inference_unit.sv
`default_nettype none
// Fully connected leaky-ReLU network, one shared multiply-accumulate unit.
// Weight, bias and feed words are taken with start while busy is low; the
// feed word with in_last high starts the forward pass: per output neuron
// the bias is loaded, each input is read, multiplied and accumulated, and
// the activation is stored, over all layers. Each output element is then
// shown on out_ ports for one cycle with out_strobe. The receiver cannot
// stall; busy is high from the last feed until the final element is shown.
module mlp_leaky_relu_inference_unit #(
  parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS_DEF,
  parameter int MAX_WIDTH  = mlp_pkg::MAX_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_operation,
  input  wire logic [1:0]         in_layer,
  input  wire logic [3:0]         in_row,
  input  wire logic [3:0]         in_col,
  input  wire logic signed [15:0] in_value,
  input  wire logic               in_last,
  output logic                    out_strobe,
  output logic signed [15:0]      out_result_value,
  output logic [3:0]              out_result_index,
  output logic                    out_result_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [4:0]         cfg_data
);

  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int IW = $clog2(MAX_WIDTH);

  mlp_pkg::cmd_t cmd;
  logic [LW-1:0] lyr;
  logic [IW-1:0] row_idx, col_idx;

  assign cfg_ready = 1'b1;
  assign out_result_index = 4'(col_idx);

  mlp_ctrl #(.MAX_LAYERS(MAX_LAYERS), .MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk, .rst_n, .start, .in_operation, .in_last,
    .cfg_valid, .cfg_index, .cfg_data,
    .busy, .cmd, .lyr, .row_idx, .col_idx, .out_strobe, .out_result_last
  );

  mlp_dp #(.MAX_LAYERS(MAX_LAYERS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk, .cmd, .lyr, .row_idx, .col_idx,
    .in_operation, .in_layer, .in_row, .in_col, .in_value,
    .out_result_value
  );

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result word while idle");
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == mlp_pkg::OP_FEED && in_last) |=> busy)
    else $error("last feed did not start pass");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_last) |=> !busy) else $error("busy after final word");
`endif

endmodule
`default_nettype wire

// File: rtl/mlp_dp.sv
`default_nettype none
module mlp_dp #(
  parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS_DEF,
  parameter int MAX_WIDTH  = mlp_pkg::MAX_WIDTH_DEF,
  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1,
  localparam int IW = $clog2(MAX_WIDTH)
) (
  input  wire logic                clk,
  input  wire mlp_pkg::cmd_t       cmd,
  input  wire logic [LW-1:0]       lyr,
  input  wire logic [IW-1:0]       row_idx,
  input  wire logic [IW-1:0]       col_idx,
  input  wire logic [1:0]          in_operation,
  input  wire logic [1:0]          in_layer,
  input  wire logic [3:0]          in_row,
  input  wire logic [3:0]          in_col,
  input  wire logic signed [15:0]  in_value,
  output logic signed [15:0]       out_result_value
);

  localparam int WD  = MAX_LAYERS * MAX_WIDTH * MAX_WIDTH;
  localparam int WAW = $clog2(WD);
  localparam int BD  = MAX_LAYERS * MAX_WIDTH;
  localparam int BAW = $clog2(BD);
  localparam int AD  = 2 * MAX_WIDTH;
  localparam int AAW = $clog2(AD);

  logic signed [15:0] w_mem [WD];
  logic signed [15:0] b_mem [BD];
  logic signed [15:0] a_mem [AD];

  logic signed [15:0] w_rd_r, b_rd_r, a_rd_r;
  logic signed [31:0] prod_r, acc_r;

  logic in_ok_w, in_ok_b, in_ok_f;
  logic [WAW-1:0] w_wr_addr, w_rd_addr;
  logic [BAW-1:0] b_wr_addr, b_rd_addr;
  logic [AAW-1:0] a_wr_addr, a_rd_addr;
  logic signed [15:0] a_wr_data;
  logic a_we;
  logic signed [32:0] sum, rnd;
  logic signed [31:0] acc_nxt;
  logic signed [24:0] y;
  logic signed [15:0] ysat;
  logic signed [22:0] yneg;
  logic signed [15:0] act_val;

  assign in_ok_w = cmd.take && (in_operation == mlp_pkg::OP_WEIGHT) &&
                   (32'(in_layer) < MAX_LAYERS) && (32'(in_row) < MAX_WIDTH) &&
                   (32'(in_col) < MAX_WIDTH);
  assign in_ok_b = cmd.take && (in_operation == mlp_pkg::OP_BIAS) &&
                   (32'(in_layer) < MAX_LAYERS) && (32'(in_col) < MAX_WIDTH);
  assign in_ok_f = cmd.take && (in_operation == mlp_pkg::OP_FEED) &&
                   (32'(in_row) < MAX_WIDTH);

  assign w_wr_addr = WAW'((32'(in_layer) * MAX_WIDTH + 32'(in_row)) * MAX_WIDTH + 32'(in_col));
  assign w_rd_addr = WAW'((32'(lyr) * MAX_WIDTH + 32'(row_idx)) * MAX_WIDTH + 32'(col_idx));
  assign b_wr_addr = BAW'(32'(in_layer) * MAX_WIDTH + 32'(in_col));
  assign b_rd_addr = BAW'(32'(lyr) * MAX_WIDTH + 32'(col_idx));

  always_comb begin
    if (cmd.act_wr) begin
      a_wr_addr = AAW'(32'(!cmd.src_bank) * MAX_WIDTH + 32'(col_idx));
      a_wr_data = act_val;
      a_we      = 1'b1;
    end else begin
      a_wr_addr = AAW'(32'(in_row));
      a_wr_data = in_value;
      a_we      = in_ok_f;
    end
    a_rd_addr = AAW'(32'(cmd.src_bank) * MAX_WIDTH + 32'(cmd.rd_col ? col_idx : row_idx));
  end

  always_ff @(posedge clk) begin
    if (in_ok_w) w_mem[w_wr_addr] <= in_value;
    if (in_ok_b) b_mem[b_wr_addr] <= in_value;
    if (a_we)    a_mem[a_wr_addr] <= a_wr_data;
    w_rd_r <= w_mem[w_rd_addr];
    b_rd_r <= b_mem[b_rd_addr];
    a_rd_r <= a_mem[a_rd_addr];
  end

  always_comb begin
    sum = {acc_r[31], acc_r} + {prod_r[31], prod_r};
    if (sum > 33'sd2147483647)       acc_nxt = 32'sh7fffffff;
    else if (sum < -33'sd2147483648) acc_nxt = 32'sh80000000;
    else                             acc_nxt = sum[31:0];
    rnd = {acc_r[31], acc_r} + 33'sd128;
    y   = rnd[32:8];
    if (y > 25'sd32767)       ysat = 16'sh7fff;
    else if (y < -25'sd32768) ysat = 16'sh8000;
    else                      ysat = y[15:0];
    yneg = 23'(ysat) * 23'sd41;
    if (ysat[15]) act_val = 16'($signed(yneg[22:12]));
    else          act_val = ysat;
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en) prod_r <= 32'(a_rd_r) * 32'(w_rd_r);
    if (cmd.acc_load) acc_r <= {{8{b_rd_r[15]}}, b_rd_r, 8'h00};
    else if (cmd.acc_add) acc_r <= acc_nxt;
  end

  assign out_result_value = a_rd_r;

endmodule
`default_nettype wire

// File: rtl/mlp_ctrl.sv
`default_nettype none
module mlp_ctrl #(
  parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS_DEF,
  parameter int MAX_WIDTH  = mlp_pkg::MAX_WIDTH_DEF,
  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1,
  localparam int IW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    in_operation,
  input  wire logic          in_last,
  input  wire logic          cfg_valid,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [4:0]    cfg_data,
  output logic               busy,
  output mlp_pkg::cmd_t      cmd,
  output logic [LW-1:0]      lyr,
  output logic [IW-1:0]      row_idx,
  output logic [IW-1:0]      col_idx,
  output logic               out_strobe,
  output logic               out_result_last
);

  localparam int WCAP = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;
  localparam int LCAP = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BIAS  = 3'd1;
  localparam logic [2:0] S_BLOAD = 3'd2;
  localparam logic [2:0] S_MRD   = 3'd3;
  localparam logic [2:0] S_MMUL  = 3'd4;
  localparam logic [2:0] S_MACC  = 3'd5;
  localparam logic [2:0] S_ACT   = 3'd6;
  localparam logic [2:0] S_EOUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] lyr_r, lyr_nxt;
  logic [IW-1:0] c_r, c_nxt, r_r, r_nxt;
  logic src_r, src_nxt, erd_r, erd_nxt;
  logic [4:0] w_r [6];
  logic [4:0] wid [5];
  logic [2:0] layers_m1, layers;
  logic take, r_last, c_last, e_last;

  function automatic logic [4:0] clampw(input logic [4:0] w);
    if (w == 5'd0) return 5'd1;
    if (32'(w) > WCAP) return 5'(WCAP);
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r[0] <= 5'd1;
      for (int i = 1; i < 6; i++) w_r[i] <= 5'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mlp_pkg::REG_LAYER_COUNT: w_r[0] <= {2'b00, cfg_data[2:0]};
        mlp_pkg::REG_WIDTH_IN:    w_r[1] <= cfg_data;
        mlp_pkg::REG_WIDTH_HID1:  w_r[2] <= cfg_data;
        mlp_pkg::REG_WIDTH_HID2:  w_r[3] <= cfg_data;
        mlp_pkg::REG_WIDTH_HID3:  w_r[4] <= cfg_data;
        mlp_pkg::REG_WIDTH_OUT4:  w_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) wid[i] = clampw(w_r[i+1]);
    if (w_r[0][2:0] == 3'd0) layers = 3'd1;
    else if (32'(w_r[0][2:0]) > LCAP) layers = 3'(LCAP);
    else layers = w_r[0][2:0];
    layers_m1 = layers - 3'd1;
  end

  assign take   = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign r_last = (r_r == IW'(wid[lyr_r] - 5'd1));
  assign c_last = (c_r == IW'(wid[lyr_r + 3'd1] - 5'd1));
  assign e_last = (c_r == IW'(wid[layers] - 5'd1));

  always_comb begin
    state_nxt = state_r;
    lyr_nxt   = lyr_r;
    c_nxt     = c_r;
    r_nxt     = r_r;
    src_nxt   = src_r;
    erd_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take && (in_operation == mlp_pkg::OP_FEED) && in_last) begin
          lyr_nxt = 3'd0; c_nxt = '0; src_nxt = 1'b0; state_nxt = S_BIAS;
        end
      end
      S_BIAS:  state_nxt = S_BLOAD;
      S_BLOAD: begin r_nxt = '0; state_nxt = S_MRD; end
      S_MRD:   state_nxt = S_MMUL;
      S_MMUL:  state_nxt = S_MACC;
      S_MACC: begin
        if (r_last) state_nxt = S_ACT;
        else begin r_nxt = r_r + 1'b1; state_nxt = S_MRD; end
      end
      S_ACT: begin
        if (c_last) begin
          c_nxt = '0;
          src_nxt = !src_r;
          if (lyr_r == layers_m1) begin
            erd_nxt = 1'b1; state_nxt = S_EOUT;
          end else begin
            lyr_nxt = lyr_r + 3'd1; state_nxt = S_BIAS;
          end
        end else begin
          c_nxt = c_r + 1'b1; state_nxt = S_BIAS;
        end
      end
      S_EOUT: begin
        if (erd_r) state_nxt = S_EOUT;
        else if (e_last) state_nxt = S_IDLE;
        else begin c_nxt = c_r + 1'b1; erd_nxt = 1'b1; end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lyr_r   <= 3'd0;
      c_r     <= '0;
      r_r     <= '0;
      src_r   <= 1'b0;
      erd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lyr_r   <= lyr_nxt;
      c_r     <= c_nxt;
      r_r     <= r_nxt;
      src_r   <= src_nxt;
      erd_r   <= erd_nxt;
    end
  end

  always_comb begin
    cmd.take     = take;
    cmd.acc_load = (state_r == S_BLOAD);
    cmd.prod_en  = (state_r == S_MMUL);
    cmd.acc_add  = (state_r == S_MACC);
    cmd.act_wr   = (state_r == S_ACT);
    cmd.src_bank = src_r;
    cmd.rd_col   = (state_r == S_EOUT);
  end

  assign lyr             = LW'(lyr_r);
  assign row_idx         = r_r;
  assign col_idx         = c_r;
  assign out_strobe      = (state_r == S_EOUT) && !erd_r;
  assign out_result_last = e_last;

endmodule
`default_nettype wire
